[rtl/core/edge_clamped_window_average_assert.svh]
// Assertion macros shared by the checker of edge_clamped_window_average.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef EDGE_CLAMPED_WINDOW_AVERAGE_ASSERT_SVH
`define EDGE_CLAMPED_WINDOW_AVERAGE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ECWA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ecwa check failed: same-cycle property");

// Next-cycle implication, checked out of reset.
`define ECWA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ecwa check failed: next-cycle property");

`endif

[rtl/core/ecwa_pkg.sv]
// Package for edge_clamped_window_average: sizes, register indexes, codes,
// payload structs and the controller state type. No dependencies.
package ecwa_pkg;

    localparam int MAX_DIMS    = 64;
    localparam int DIM_W       = $clog2(MAX_DIMS);
    localparam int CNT_W       = DIM_W + 1;
    localparam int MAX_HALF    = 7;
    localparam int HALF_W      = 3;
    localparam int RING_FRAMES = 16;
    localparam int SLOT_W      = $clog2(RING_FRAMES);
    localparam int RING_DEPTH  = RING_FRAMES * MAX_DIMS;
    localparam int ADDR_W      = $clog2(RING_DEPTH);
    localparam int FRAMES_W    = 5;
    localparam int FRAMES_SAT  = 31;
    localparam int SAMPLE_W    = 16;
    localparam int SUM_W       = 20;
    localparam int MAG_W       = SUM_W - 1;
    localparam int WIN_W       = 4;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = MAG_W + RECIP_W;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic REG_DIMS = 1'b0;
    localparam logic REG_HALF = 1'b1;

    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct packed {
        logic                       op;
        logic signed [SAMPLE_W-1:0] sample;
    } smp_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] pooled_value;
        logic                       last;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SIGN,
        ST_DIV,
        ST_HOLD
    } state_t;

endpackage

[rtl/core/ecwa_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module ecwa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/core/edge_clamped_window_average.sv]
// Top level of edge_clamped_window_average: centered moving average with
// edge replication over a frame ring memory. Uses ecwa_pkg and ecwa_ram.
//
//   channel  | signals                         | payload
//   ---------+---------------------------------+-------------------------
//   samples  | smp_valid, smp_stall            | smp_item (op, sample)
//   results  | res_valid, res_stall            | res_item (value, last)
//   config   | psel penable pwrite paddr pwdata| dims @0x0, half @0x4
//
// Steps: an item that yields a result takes its accept, the ring reads of its
// 2h+1 taps, a drain of the read pipe, a sign step, a reciprocal multiply
// and a hold step before the next accept; an item with no result leaves the
// controller idle, ready for the next item. The single ring read port sets that.
// Reset clears counters and config; ring contents stay undefined.
// A stalled result holds in the output register while the next item works;
// the hold cycle waits until that register is free.

module edge_clamped_window_average (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                smp_valid,
    output logic                                smp_stall,
    input  ecwa_pkg::smp_t                      smp_item,
    output logic                                res_valid,
    input  logic                                res_stall,
    output ecwa_pkg::res_t                      res_item,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ecwa_pkg::PADDR_W-1:0]        paddr,
    input  logic [ecwa_pkg::PDATA_W-1:0]        pwdata,
    output logic [ecwa_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    // Configuration registers
    logic [ecwa_pkg::CNT_W-1:0]  dims_reg;
    logic [ecwa_pkg::HALF_W-1:0] half_reg;
    logic                        cfg_wr;

    // Sequence counters
    logic [ecwa_pkg::DIM_W-1:0]    dpos_reg,  dpos_next;
    logic [ecwa_pkg::FRAMES_W-1:0] fseen_reg, fseen_next;
    logic [ecwa_pkg::SLOT_W-1:0]   head_reg,  head_next;
    logic [ecwa_pkg::HALF_W-1:0]   fleft_reg, fleft_next;

    // Per-item context captured at accept
    logic                          flush_reg,  flush_next;
    logic [ecwa_pkg::SLOT_W-1:0]   base_reg,   base_next;
    logic [ecwa_pkg::DIM_W-1:0]    d_reg,      d_next;
    logic [ecwa_pkg::FRAMES_W-1:0] len_reg,    len_next;
    logic [ecwa_pkg::HALF_W-1:0]   r_reg,      r_next;
    logic [ecwa_pkg::HALF_W-1:0]   h_reg,      h_next;
    logic                          last_reg,   last_next;
    logic                          emit;

    // Tap walk and divider
    ecwa_pkg::state_t              state_reg, state_next;
    logic [ecwa_pkg::WIN_W-1:0]    k_reg;
    logic                          pend_reg;
    logic signed [ecwa_pkg::SUM_W-1:0] sum_reg;
    logic [ecwa_pkg::MAG_W-1:0]    dvd_reg;
    logic                          neg_reg;

    // Output register
    logic                          res_valid_reg;
    ecwa_pkg::res_t                res_item_reg;

    // Derived
    logic [ecwa_pkg::CNT_W-1:0]    nd;
    logic [ecwa_pkg::HALF_W-1:0]   h_eff;
    logic                          accept;
    logic [ecwa_pkg::WIN_W-1:0]    last_k;
    logic [ecwa_pkg::WIN_W-1:0]    age;
    logic signed [5:0]             fage;
    logic [ecwa_pkg::SLOT_W-1:0]   rd_slot;
    logic                          issue;
    logic                          out_free;
    logic                          ram_wr;
    logic [ecwa_pkg::ADDR_W-1:0]   ram_waddr;
    logic [ecwa_pkg::SAMPLE_W-1:0] ram_rdata;
    logic [ecwa_pkg::RECIP_W-1:0]  recip;
    logic [ecwa_pkg::PROD_W-1:0]   prod;
    logic [ecwa_pkg::SUM_W-1:0]    mag;
    logic [ecwa_pkg::SAMPLE_W-1:0] quo;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg <= ecwa_pkg::CNT_W'(1);
            half_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                ecwa_pkg::REG_DIMS: dims_reg <= pwdata[ecwa_pkg::CNT_W-1:0];
                ecwa_pkg::REG_HALF: half_reg <= pwdata[ecwa_pkg::HALF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            ecwa_pkg::REG_DIMS: prdata = {{(ecwa_pkg::PDATA_W-ecwa_pkg::CNT_W){1'b0}}, dims_reg};
            ecwa_pkg::REG_HALF: prdata = {{(ecwa_pkg::PDATA_W-ecwa_pkg::HALF_W){1'b0}}, half_reg};
            default:            prdata = '0;
        endcase
    end

    // Clamp dims to 1..MAX_DIMS; half width needs no clamp at 3 bits.
    always_comb
    begin
        if (dims_reg == '0)
            nd = ecwa_pkg::CNT_W'(1);
        else if (dims_reg > ecwa_pkg::CNT_W'(ecwa_pkg::MAX_DIMS))
            nd = ecwa_pkg::CNT_W'(ecwa_pkg::MAX_DIMS);
        else
            nd = dims_reg;
    end
    assign h_eff = half_reg;

    // ------------------------------------------------------------------
    // Accept: update counters and capture the item's context
    // ------------------------------------------------------------------
    assign accept = smp_valid && !smp_stall;

    always_comb
    begin
        logic [ecwa_pkg::DIM_W-1:0]    dp;
        logic [ecwa_pkg::FRAMES_W-1:0] fs;
        logic [ecwa_pkg::SLOT_W-1:0]   hd;
        logic [ecwa_pkg::HALF_W-1:0]   r;
        logic [ecwa_pkg::DIM_W-1:0]    d;
        logic [ecwa_pkg::CNT_W-1:0]    dn;

        dp = dpos_reg;
        fs = fseen_reg;
        hd = head_reg;
        r  = fleft_reg;
        d  = '0;
        dn = '0;

        dpos_next  = dpos_reg;
        fseen_next = fseen_reg;
        head_next  = head_reg;
        fleft_next = fleft_reg;
        flush_next = flush_reg;
        base_next  = base_reg;
        d_next     = d_reg;
        len_next   = len_reg;
        r_next     = r_reg;
        h_next     = h_reg;
        last_next  = last_reg;
        emit       = 1'b0;
        ram_wr     = 1'b0;
        ram_waddr  = '0;

        if (accept)
        begin
            h_next     = h_eff;
            flush_next = smp_item.op;
            last_next  = 1'b0;
            if (smp_item.op == ecwa_pkg::OP_DATA)
            begin
                // Data during a flush abandons it and starts a new sequence.
                if (fleft_reg != '0)
                begin
                    dp = '0;
                    fs = '0;
                    hd = '0;
                end
                if ({1'b0, dp} >= nd)
                    dp = '0;
                d         = dp;
                ram_wr    = 1'b1;
                ram_waddr = {hd, d};
                emit      = fs >= ecwa_pkg::FRAMES_W'(h_eff);
                base_next = hd;
                d_next    = d;
                len_next  = fs;
                dn        = {1'b0, d} + ecwa_pkg::CNT_W'(1);
                fleft_next = '0;
                if (dn >= nd)
                begin
                    dpos_next = '0;
                    if (fs < ecwa_pkg::FRAMES_W'(ecwa_pkg::FRAMES_SAT))
                        fs = fs + ecwa_pkg::FRAMES_W'(1);
                    hd = hd + ecwa_pkg::SLOT_W'(1);
                end
                else
                begin
                    dpos_next = dn[ecwa_pkg::DIM_W-1:0];
                end
                fseen_next = fs;
                head_next  = hd;
            end
            else
            begin
                if (fleft_reg == '0)
                begin
                    r  = (fs < ecwa_pkg::FRAMES_W'(h_eff)) ? fs[ecwa_pkg::HALF_W-1:0] : h_eff;
                    dp = '0;
                end
                if (r == '0 || fs == '0)
                begin
                    // Nothing pending: close the sequence with no result.
                    dpos_next  = '0;
                    fseen_next = '0;
                    head_next  = '0;
                    fleft_next = '0;
                end
                else
                begin
                    emit = 1'b1;
                    if ({1'b0, dp} >= nd)
                        dp = '0;
                    d         = dp;
                    base_next = hd - ecwa_pkg::SLOT_W'(1);
                    d_next    = d;
                    len_next  = fs;
                    r_next    = r;
                    dn        = {1'b0, d} + ecwa_pkg::CNT_W'(1);
                    if (dn >= nd)
                    begin
                        dpos_next  = '0;
                        fleft_next = r - ecwa_pkg::HALF_W'(1);
                        if (r == ecwa_pkg::HALF_W'(1))
                        begin
                            last_next  = 1'b1;
                            fseen_next = '0;
                            head_next  = '0;
                        end
                    end
                    else
                    begin
                        dpos_next  = dn[ecwa_pkg::DIM_W-1:0];
                        fleft_next = r;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tap address: data clamps age at the frame count, flush clamps the
    // window to [first, last] frame of the sequence.
    // ------------------------------------------------------------------
    assign last_k = {h_reg, 1'b0};

    always_comb
    begin
        fage = 6'(signed'({3'b000, r_reg})) - 6'sd1 + 6'(signed'({3'b000, h_reg}))
             - 6'(signed'({2'b00, k_reg}));
        if (!flush_reg)
        begin
            age = ({1'b0, k_reg} < len_reg) ? k_reg : len_reg[ecwa_pkg::WIN_W-1:0];
        end
        else if (fage < 6'sd0)
        begin
            age = '0;
        end
        else if (fage[4:0] > len_reg - ecwa_pkg::FRAMES_W'(1))
        begin
            age = ecwa_pkg::WIN_W'(len_reg - ecwa_pkg::FRAMES_W'(1));
        end
        else
        begin
            age = fage[ecwa_pkg::WIN_W-1:0];
        end
        rd_slot = base_reg - age;
    end

    ecwa_ram #(
        .WIDTH (ecwa_pkg::SAMPLE_W),
        .DEPTH (ecwa_pkg::RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_wr),
        .wr_addr (ram_waddr),
        .wr_data (smp_item.sample),
        .rd_en   (issue),
        .rd_addr ({rd_slot, d_reg}),
        .rd_data (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Controller
    // ------------------------------------------------------------------
    assign out_free = !res_valid_reg || !res_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ecwa_pkg::ST_IDLE:
                if (accept && emit)
                    state_next = ecwa_pkg::ST_READ;
            ecwa_pkg::ST_READ:
                if (k_reg > last_k && !pend_reg)
                    state_next = ecwa_pkg::ST_SIGN;
            ecwa_pkg::ST_SIGN:
                state_next = ecwa_pkg::ST_DIV;
            ecwa_pkg::ST_DIV:
                state_next = ecwa_pkg::ST_HOLD;
            ecwa_pkg::ST_HOLD:
                if (out_free)
                    state_next = ecwa_pkg::ST_IDLE;
            default:
                state_next = ecwa_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        smp_stall = 1'b1;
        issue     = 1'b0;
        case (state_reg)
            ecwa_pkg::ST_IDLE: smp_stall = 1'b0;
            ecwa_pkg::ST_READ: issue     = k_reg <= last_k;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ecwa_pkg::ST_IDLE;
            dpos_reg  <= '0;
            fseen_reg <= '0;
            head_reg  <= '0;
            fleft_reg <= '0;
            pend_reg  <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            dpos_reg  <= dpos_next;
            fseen_reg <= fseen_next;
            head_reg  <= head_next;
            fleft_reg <= fleft_next;
            pend_reg  <= issue;
            if (accept)
                k_reg <= '0;
            else if (issue)
                k_reg <= k_reg + ecwa_pkg::WIN_W'(1);
        end
    end

    // Reciprocal of the window size, 2^24 / (2h+1) rounded up. Exact for
    // every magnitude below 2^19, since the error stays under 1/32.
    always_comb
    begin
        case (h_reg)
            3'd0:    recip = 25'd16777216;
            3'd1:    recip = 25'd5592406;
            3'd2:    recip = 25'd3355444;
            3'd3:    recip = 25'd2396746;
            3'd4:    recip = 25'd1864136;
            3'd5:    recip = 25'd1525202;
            3'd6:    recip = 25'd1290556;
            3'd7:    recip = 25'd1118482;
            default: recip = 25'd16777216;
        endcase
    end

    // Item context and datapath
    assign mag  = sum_reg[ecwa_pkg::SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
    assign prod = ecwa_pkg::PROD_W'(dvd_reg) * ecwa_pkg::PROD_W'(recip);
    assign quo  = neg_reg ? (~dvd_reg[ecwa_pkg::SAMPLE_W-1:0] + 1'b1)
                          : dvd_reg[ecwa_pkg::SAMPLE_W-1:0];

    always_ff @(posedge clk)
    begin
        flush_reg <= flush_next;
        base_reg  <= base_next;
        d_reg     <= d_next;
        len_reg   <= len_next;
        r_reg     <= r_next;
        h_reg     <= h_next;
        last_reg  <= last_next;
        if (accept)
            sum_reg <= '0;
        else if (pend_reg)
            sum_reg <= sum_reg + {{(ecwa_pkg::SUM_W-ecwa_pkg::SAMPLE_W){ram_rdata[ecwa_pkg::SAMPLE_W-1]}},
                                  ram_rdata};
        if (state_reg == ecwa_pkg::ST_SIGN)
        begin
            neg_reg <= sum_reg[ecwa_pkg::SUM_W-1];
            dvd_reg <= mag[ecwa_pkg::MAG_W-1:0];
        end
        else if (state_reg == ecwa_pkg::ST_DIV)
        begin
            // Truncated quotient of the magnitude: multiply and drop the fraction.
            dvd_reg <= prod[ecwa_pkg::RECIP_SHIFT +: ecwa_pkg::MAG_W];
        end
    end

    // Output register: load when the held result has been taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (state_reg == ecwa_pkg::ST_HOLD && out_free)
            res_valid_reg <= 1'b1;
        else if (!res_stall)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ecwa_pkg::ST_HOLD && out_free)
        begin
            res_item_reg.pooled_value <= quo;
            res_item_reg.last         <= last_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

endmodule

[rtl/core/ecwa_check.sv]
// Port-level checker for edge_clamped_window_average, bound to the top level.
// Uses ecwa_pkg and the macros of edge_clamped_window_average_assert.svh.
`include "edge_clamped_window_average_assert.svh"

module ecwa_check (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         smp_valid,
    input logic                         smp_stall,
    input logic                         res_valid,
    input logic                         res_stall,
    input ecwa_pkg::res_t               res_item,
    input logic                         psel,
    input logic                         pwrite,
    input logic [ecwa_pkg::PDATA_W-1:0] prdata,
    input logic                         pready
);

    // A stalled result holds its transaction.
    `ECWA_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res_item))

    // The window walk lies between accept and result: no result rises right after an accept.
    `ECWA_ASSERT_NOW(a_no_early_result, $rose(res_valid), !$past(smp_valid && !smp_stall))

    // Register reads carry no bits above the register width.
    `ECWA_ASSERT_NOW(a_prdata_narrow, psel && !pwrite, prdata[ecwa_pkg::PDATA_W-1:ecwa_pkg::CNT_W] == '0)

    // The config port never waits.
    `ECWA_ASSERT_NOW(a_pready, psel, pready)

endmodule

bind edge_clamped_window_average ecwa_check u_ecwa_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .smp_valid (smp_valid),
    .smp_stall (smp_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item),
    .psel      (psel),
    .pwrite    (pwrite),
    .prdata    (prdata),
    .pready    (pready)
);
